/* sv/lcgpsh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgpsh_pkg
// Types and constants shared by the population seed hash pipeline.
// ----------------------------------------------------------------------------
package lcgpsh_pkg;

   typedef logic [47:0] word48_type;
   typedef logic [31:0] top32_type;

   localparam int LcgCount = 4;

   localparam word48_type SeedScramble = 48'd25214903917;

   localparam word48_type LcgMul [LcgCount] = '{
      48'd25214903917,
      48'd205749139540585,
      48'd233752471717045,
      48'd55986898099985
   };

   localparam word48_type LcgAdd [LcgCount] = '{
      48'd11,
      48'd277363943098,
      48'd11718085204285,
      48'd49720483695876
   };

   localparam logic RuleHalveDouble = 1'b0;
   localparam logic RuleOrOne       = 1'b1;

endpackage

/* sv/lcgpsh_mul48.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgpsh_mul48
// Low 48 bits of a 48 x 48 product: registered partial products, summed after.
// ----------------------------------------------------------------------------
module lcgpsh_mul48 (
   input  logic               clock,
   input  lcgpsh_pkg::word48_type op_a,
   input  lcgpsh_pkg::word48_type op_b,
   output lcgpsh_pkg::word48_type product
);
   import lcgpsh_pkg::*;

   logic [63:0] lo_prod_in;
   logic [63:0] lo_prod_ff;
   logic [31:0] cross_a;
   logic [31:0] cross_b;
   logic [15:0] cross_in;
   logic [15:0] cross_ff;

   // only the low 16 bits of the cross terms land below bit 48
   assign lo_prod_in = op_a[31:0] * op_b[31:0];
   assign cross_a    = op_a[47:32] * op_b[15:0];
   assign cross_b    = op_a[15:0] * op_b[47:32];
   assign cross_in   = cross_a[15:0] + cross_b[15:0];

   always_ff @(posedge clock) begin
      lo_prod_ff <= lo_prod_in;
      cross_ff   <= cross_in;
   end

   assign product = lo_prod_ff[47:0] + {cross_ff, 32'd0};

endmodule

/* sv/lcgpsh_word.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgpsh_word
// Builds the low 48 bits of a 64-bit word from two 32-bit tops and makes it odd (two stages).
// ----------------------------------------------------------------------------
module lcgpsh_word (
   input  logic                   clock,
   input  logic                   odd_rule,
   input  lcgpsh_pkg::top32_type  top_hi,
   input  lcgpsh_pkg::top32_type  top_lo,
   output lcgpsh_pkg::word48_type word_odd
);
   import lcgpsh_pkg::*;

   logic [31:0] hi_in;
   logic        sign_ff;
   word48_type  low_ff;
   word48_type  odd_in;
   word48_type  odd_ff;

   // high half picks up -1 when the low half is sign-extended negative
   assign hi_in = top_hi - {31'd0, top_lo[31]};

   always_ff @(posedge clock) begin
      sign_ff <= hi_in[31];
      low_ff  <= {hi_in[15:0], top_lo};
   end

   always_comb begin
      if (odd_rule == RuleHalveDouble && sign_ff && low_ff[0]) begin
         odd_in = low_ff + 48'd2;
      end else begin
         odd_in = low_ff | 48'd1;
      end
   end

   always_ff @(posedge clock) begin
      odd_ff <= odd_in;
   end

   assign word_odd = odd_ff;

endmodule

/* sv/lcg_population_seed_hash.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg_population_seed_hash
// Population seed hash of a 48-bit seed and an x/z coordinate pair.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low; busy
//   is always low, so a new request may enter every cycle.
//   Request: req_seed_in, req_coord_x, req_coord_z.
//   Response: rsp_hashed_seed, valid for the one cycle rsp_strobe is high.
//   Throughput is one request per cycle, set by the fully pipelined
//   multiplier lanes (four seed steps, then two coordinate products).
//   The receiver cannot stall; every request yields exactly one response.
//   csr_wr_en / csr_wr_data write odd_rule (0 = halve-double-plus-one,
//   1 = OR one); write it only while no request is in flight.
//   Reset (synchronous, active high) clears the pipeline valid bits and
//   sets odd_rule to 0; requests in flight are dropped.
// ----------------------------------------------------------------------------
module lcg_population_seed_hash (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  lcgpsh_pkg::word48_type req_seed_in,
   input  lcgpsh_pkg::word48_type req_coord_x,
   input  lcgpsh_pkg::word48_type req_coord_z,
   output logic                   rsp_strobe,
   output lcgpsh_pkg::word48_type rsp_hashed_seed,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data
);
   import lcgpsh_pkg::*;

   localparam int ValidDepth = 7;

   logic [ValidDepth-1:0] vld_ff;
   logic [ValidDepth-1:0] vld_in;
   logic                  odd_rule_ff;

   word48_type seed_a_ff, x_a_ff, z_a_ff;
   word48_type seed_b_ff, x_b_ff, z_b_ff;
   word48_type seed_c_ff, x_c_ff, z_c_ff;
   word48_type seed_d_ff, x_d_ff, z_d_ff;
   word48_type seed_e_ff, x_e_ff, z_e_ff;
   word48_type seed_f_ff;
   word48_type hash_ff;
   word48_type hash_in;

   word48_type scrambled;
   word48_type lcg_prod [LcgCount];
   word48_type lcg_sum  [LcgCount];
   top32_type  top_ff   [LcgCount];
   word48_type mul_a;
   word48_type mul_b;
   word48_type prod_x;
   word48_type prod_z;

   assign busy   = 1'b0;
   assign vld_in = {vld_ff[ValidDepth-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         odd_rule_ff <= RuleHalveDouble;
      end else begin
         vld_ff <= vld_in;
         if (csr_wr_en) begin
            odd_rule_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      seed_a_ff <= req_seed_in;
      x_a_ff    <= req_coord_x;
      z_a_ff    <= req_coord_z;
      seed_b_ff <= seed_a_ff;
      x_b_ff    <= x_a_ff;
      z_b_ff    <= z_a_ff;
      seed_c_ff <= seed_b_ff;
      x_c_ff    <= x_b_ff;
      z_c_ff    <= z_b_ff;
      seed_d_ff <= seed_c_ff;
      x_d_ff    <= x_c_ff;
      z_d_ff    <= z_c_ff;
      seed_e_ff <= seed_d_ff;
      x_e_ff    <= x_d_ff;
      z_e_ff    <= z_d_ff;
      seed_f_ff <= seed_e_ff;
      hash_ff   <= hash_in;
   end

   assign scrambled = seed_a_ff ^ SeedScramble;

   for (genvar i = 0; i < LcgCount; i++) begin : g_lcg
      lcgpsh_mul48 u_mul (
         .clock   (clock),
         .op_a    (scrambled),
         .op_b    (LcgMul[i]),
         .product (lcg_prod[i])
      );

      assign lcg_sum[i] = lcg_prod[i] + LcgAdd[i];

      always_ff @(posedge clock) begin
         top_ff[i] <= lcg_sum[i][47:16];
      end
   end

   lcgpsh_word u_word_a (
      .clock    (clock),
      .odd_rule (odd_rule_ff),
      .top_hi   (top_ff[0]),
      .top_lo   (top_ff[1]),
      .word_odd (mul_a)
   );

   lcgpsh_word u_word_b (
      .clock    (clock),
      .odd_rule (odd_rule_ff),
      .top_hi   (top_ff[2]),
      .top_lo   (top_ff[3]),
      .word_odd (mul_b)
   );

   lcgpsh_mul48 u_mul_x (
      .clock   (clock),
      .op_a    (x_e_ff),
      .op_b    (mul_a),
      .product (prod_x)
   );

   lcgpsh_mul48 u_mul_z (
      .clock   (clock),
      .op_a    (z_e_ff),
      .op_b    (mul_b),
      .product (prod_z)
   );

   assign hash_in = (prod_x + prod_z) ^ seed_f_ff;

   assign rsp_strobe      = vld_ff[ValidDepth-1];
   assign rsp_hashed_seed = hash_ff;

endmodule

/* dv/lcgpsh_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcgpsh_tb_pkg
// Scoreboard for the population seed hash. It predicts hashed_seed for each
// accepted request under the current odd_rule. It then checks the responses
// in order.
// ----------------------------------------------------------------------------
package lcgpsh_tb_pkg;

   import lcgpsh_pkg::*;

   class hash_scoreboard;

      logic       odd_rule;
      word48_type pending_hashes[$];
      int         mismatches;
      int         responses_seen;

      function new();
         odd_rule       = RuleHalveDouble;
         mismatches     = 0;
         responses_seen = 0;
      endfunction

      // two 64-bit words built from the four truncated LCG steps
      function void seed_words(input word48_type seed, output logic [63:0] w1,
                               output logic [63:0] w2);
         word48_type state;
         word48_type step;
         top32_type  top [LcgCount];
         state = seed ^ SeedScramble;
         for (int i = 0; i < LcgCount; i++) begin
            step   = state * LcgMul[i] + LcgAdd[i];
            top[i] = step[47:16];
         end
         w1 = {top[0], 32'd0} + {{32{top[1][31]}}, top[1]};
         w2 = {top[2], 32'd0} + {{32{top[3][31]}}, top[3]};
      endfunction

      function logic [63:0] make_word_odd(input logic [63:0] w);
         // halving a negative odd word toward zero rounds it up by one step
         if (odd_rule == RuleHalveDouble && w[63] && w[0])
            return w + 64'd2;
         return w | 64'd1;
      endfunction

      function word48_type population_hash(input word48_type seed, input word48_type x,
                                           input word48_type z);
         logic [63:0] w1;
         logic [63:0] w2;
         logic [63:0] sum;
         seed_words(seed, w1, w2);
         sum = {16'd0, x} * make_word_odd(w1) + {16'd0, z} * make_word_odd(w2);
         return sum[47:0] ^ seed;
      endfunction

      // true when the two rules disagree for this seed
      function bit negative_odd_seed(input word48_type seed);
         logic [63:0] w1;
         logic [63:0] w2;
         seed_words(seed, w1, w2);
         return (w1[63] & w1[0]) | (w2[63] & w2[0]);
      endfunction

      function void note_request(input word48_type seed, input word48_type x,
                                 input word48_type z);
         pending_hashes.insert(pending_hashes.size(), population_hash(seed, x, z));
      endfunction

      function void check_response(input word48_type actual);
         word48_type expected;
         responses_seen++;
         if (pending_hashes.size() == 0) begin
            $error("hashed_seed: unexpected response, actual %h", actual);
            mismatches++;
         end else begin
            expected = pending_hashes.pop_front();
            if (actual !== expected) begin
               $error("hashed_seed: expected %h, actual %h", expected, actual);
               mismatches++;
            end
         end
      endfunction

   endclass

endpackage

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lcg_population_seed_hash. It starts with a directed
// set under each odd_rule: extreme seeds and coordinates, and seeds whose
// words are negative and odd. Random requests follow across several odd_rule
// phases, with random sender gaps. Every response is checked in order.
// ----------------------------------------------------------------------------
module testbench;

   import lcgpsh_pkg::*;
   import lcgpsh_tb_pkg::*;

   localparam int PipeLatency  = 7;
   localparam int StallLimit   = 1000;
   localparam int RandomPhases = 4;
   localparam int PhaseItems   = 333;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       start       = 1'b0;
   logic       busy;
   word48_type req_seed_in = '0;
   word48_type req_coord_x = '0;
   word48_type req_coord_z = '0;
   logic       rsp_strobe;
   word48_type rsp_hashed_seed;
   logic       csr_wr_en   = 1'b0;
   logic       csr_wr_data = 1'b0;

   hash_scoreboard board;
   bit             gaps_enabled = 1'b1;
   int             requests_sent = 0;
   int             rule_writes = 0;
   int             quiet_cycles = 0;

   lcg_population_seed_hash u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_seed_in     (req_seed_in),
      .req_coord_x     (req_coord_x),
      .req_coord_z     (req_coord_z),
      .rsp_strobe      (rsp_strobe),
      .rsp_hashed_seed (rsp_hashed_seed),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            board.note_request(req_seed_in, req_coord_x, req_coord_z);
            requests_sent++;
         end
         if (rsp_strobe)
            board.check_response(rsp_hashed_seed);
         if (csr_wr_en)
            board.odd_rule = csr_wr_data;
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= StallLimit) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   function automatic word48_type rand_word48();
      return word48_type'({$urandom, $urandom});
   endfunction

   function automatic word48_type pick_coord();
      word48_type small_val;
      small_val = word48_type'($urandom_range(1, 255));
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return small_val;
         3: return '0 - small_val;
         default: return rand_word48();
      endcase
   endfunction

   function automatic word48_type pick_seed();
      case ($urandom_range(0, 19))
         0: return '0;
         1: return '1;
         2: return SeedScramble;
         3: return SeedScramble ^ word48_type'($urandom_range(0, 65535));
         default: return rand_word48();
      endcase
   endfunction

   function automatic word48_type find_negative_odd_seed();
      word48_type seed;
      seed = rand_word48();
      while (!board.negative_odd_seed(seed))
         seed = rand_word48();
      return seed;
   endfunction

   task automatic send_request(input word48_type seed, input word48_type x,
                               input word48_type z);
      while (gaps_enabled && $urandom_range(0, 99) < 15) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start       <= 1'b1;
      req_seed_in <= seed;
      req_coord_x <= x;
      req_coord_z <= z;
      do
         @(posedge clock);
      while (busy);
   endtask

   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending_hashes.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_odd_rule(input logic rule);
      drain_responses();
      repeat (PipeLatency + 3) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rule;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      rule_writes++;
   endtask

   task automatic run_directed();
      word48_type top_bit;
      top_bit = word48_type'(1) << 47;
      send_request('0, '0, '0);
      send_request('1, '1, '1);
      send_request(SeedScramble, 48'd1, 48'd1);
      send_request('0, '1, '0);
      send_request('0, '0, '1);
      send_request('1, top_bit, top_bit);
      send_request(rand_word48(), 48'd1, '0);
      send_request(rand_word48(), '0, 48'd1);
      send_request(find_negative_odd_seed(), rand_word48(), rand_word48());
      send_request(find_negative_odd_seed(), '1, '1);
      send_request(find_negative_odd_seed(), 48'd1, 48'd1);
      send_request(rand_word48(), rand_word48(), rand_word48());
   endtask

   initial begin
      logic phase_rule;
      board = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_odd_rule(RuleHalveDouble);
      run_directed();
      write_odd_rule(RuleOrOne);
      run_directed();

      for (int p = 0; p < RandomPhases; p++) begin
         phase_rule = (p % 2 == 0) ? RuleOrOne : RuleHalveDouble;
         if (p != 0)
            write_odd_rule(phase_rule);
         for (int i = 0; i < PhaseItems; i++) begin
            // one long run back to back with no sender gaps
            gaps_enabled = !(p == 2 && i < 250);
            send_request(pick_seed(), pick_coord(), pick_coord());
         end
      end

      drain_responses();
      repeat (PipeLatency + 3) @(posedge clock);
      if (board.pending_hashes.size() != 0) begin
         $error("hashed_seed: %0d expected responses never arrived",
                board.pending_hashes.size());
         board.mismatches++;
      end

      $display("Sent %0d requests, checked %0d responses, %0d odd_rule writes.",
               requests_sent, board.responses_seen, rule_writes);
      $display("Both odd rules exercised, including negative odd words.");
      if (board.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
